FILE: hdl/tpd_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the two-part length-prefixed deframer.
// Depends on nothing; every other file but tpd_if imports it.
package tpd_pkg;

  // Default width of the length accumulator and the data byte counter.
  localparam int LENGTH_WIDTH_DEFAULT = 32;
  // Largest legal header byte; the part then carries MAX_HEADER + 1 length bytes.
  localparam logic [7:0] MAX_HEADER = 8'd3;
  // Length bytes at most, and the span of bits that they can fill.
  localparam int LEN_BYTES = 4;
  localparam int LEN_SPAN = 8 * LEN_BYTES;
  // Entries in the queue between the parser and the output stage.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_body;
    logic       last_of_part;
    logic       empty_part;
    logic       bad_header;
  } tpd_result_t;

  // What the parser hands to the queue.
  typedef struct packed {
    logic        push;
    tpd_result_t res;
  } tpd_push_t;

endpackage

FILE: hdl/tpd_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the deframer: the received byte stream and the result stream.
// Self-contained; no package is needed.
interface tpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface tpd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_body;
  logic       last_of_part;
  logic       empty_part;
  logic       bad_header;

  modport source (output valid, output data_byte, output is_body, output last_of_part,
                  output empty_part, output bad_header, input ready);
  modport sink (input valid, input data_byte, input is_body, input last_of_part,
                input empty_part, input bad_header, output ready);
endinterface

FILE: hdl/tpd_front.sv
`timescale 1ns / 1ps
// Parser of the deframer: accepts bytes, tracks phase, part and lengths, and
// pushes result items into the queue. Depends on tpd_pkg and tpd_if.
module tpd_front
  import tpd_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  tpd_byte_if.sink   in_ch,
  input  logic       q_full,
  output tpd_push_t  q_in
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_LENGTH = 3'b010,
    PH_DATA   = 3'b100
  } phase_t;

  phase_t                  phase, phase_next;
  logic                    in_body_part, in_body_part_next;
  logic [1:0]              len_left, len_left_next;
  logic [1:0]              len_idx, len_idx_next;
  logic [LENGTH_WIDTH-1:0] len_acc, len_acc_next;
  logic [LENGTH_WIDTH-1:0] data_left, data_left_next;

  logic                    accept;
  logic [LEN_SPAN-1:0]     shifted;
  logic [LENGTH_WIDTH-1:0] acc_new;
  logic [LENGTH_WIDTH-1:0] data_dec;
  tpd_push_t               push_c;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign shifted  = LEN_SPAN'(in_ch.in_byte) << {len_idx, 3'b000};
  assign acc_new  = len_acc | shifted[LENGTH_WIDTH-1:0];
  assign data_dec = data_left - LENGTH_WIDTH'(1);

  always_comb begin
    phase_next        = phase;
    in_body_part_next = in_body_part;
    len_left_next     = len_left;
    len_idx_next      = len_idx;
    len_acc_next      = len_acc;
    data_left_next    = data_left;
    push_c            = '0;
    push_c.res.is_body = in_body_part;
    case (phase)
      PH_LENGTH: begin
        len_idx_next = len_idx + 2'd1;
        len_acc_next = acc_new;
        if (len_left != 2'd0) begin
          len_left_next = len_left - 2'd1;
        end else if (acc_new == '0) begin
          push_c.push            = 1'b1;
          push_c.res.last_of_part = 1'b1;
          push_c.res.empty_part  = 1'b1;
          in_body_part_next      = !in_body_part;
          phase_next             = PH_HEADER;
          len_left_next          = '0;
          len_idx_next           = '0;
          len_acc_next           = '0;
          data_left_next         = '0;
        end else begin
          data_left_next = acc_new;
          phase_next     = PH_DATA;
        end
      end
      PH_DATA: begin
        data_left_next        = data_dec;
        push_c.push           = 1'b1;
        push_c.res.data_byte  = in_ch.in_byte;
        if (data_dec == '0) begin
          push_c.res.last_of_part = 1'b1;
          in_body_part_next       = !in_body_part;
          phase_next              = PH_HEADER;
          len_left_next           = '0;
          len_idx_next            = '0;
          len_acc_next            = '0;
        end
      end
      default: begin
        // Header phase; an unused code behaves the same way.
        if (in_ch.in_byte > MAX_HEADER) begin
          push_c.push           = 1'b1;
          push_c.res.bad_header = 1'b1;
          in_body_part_next     = 1'b0;
          phase_next            = PH_HEADER;
        end else begin
          phase_next    = PH_LENGTH;
          len_left_next = in_ch.in_byte[1:0];
        end
        len_left_next  = (in_ch.in_byte > MAX_HEADER) ? 2'd0 : in_ch.in_byte[1:0];
        len_idx_next   = '0;
        len_acc_next   = '0;
        data_left_next = '0;
      end
    endcase
  end

  always_comb begin
    q_in      = push_c;
    q_in.push = push_c.push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      in_body_part <= 1'b0;
      len_left     <= '0;
      len_idx      <= '0;
      len_acc      <= '0;
      data_left    <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      in_body_part <= in_body_part_next;
      len_left     <= len_left_next;
      len_idx      <= len_idx_next;
      len_acc      <= len_acc_next;
      data_left    <= data_left_next;
    end
  end

  a_empty_marker_shape: assert property (@(posedge clk) disable iff (rst)
    (q_in.push && q_in.res.empty_part) |->
      (q_in.res.last_of_part && q_in.res.data_byte == 8'd0 && !q_in.res.bad_header))
    else $error("empty-part marker carries data or lacks the last flag");

  a_bad_header_restart: assert property (@(posedge clk) disable iff (rst)
    (q_in.push && q_in.res.bad_header) |=> (phase == PH_HEADER && !in_body_part))
    else $error("parser did not restart at the name header after a bad header");

endmodule

FILE: hdl/tpd_queue.sv
`timescale 1ns / 1ps
// Short queue of result items between the parser and the output stage.
// Depends on tpd_pkg.
module tpd_queue
  import tpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tpd_push_t   q_in,
  output logic        q_full,
  output logic        q_valid,
  input  logic        q_pop,
  output tpd_result_t q_out
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tpd_result_t      mem [QUEUE_DEPTH];
  logic [IDX_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign q_full  = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign do_push = q_in.push && !q_full;
  assign do_pop  = q_pop && q_valid;
  assign q_out   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= q_in.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count above its depth");

  a_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_in.push)
    else $error("parser pushed a result item into a full queue");

endmodule

FILE: hdl/tpd_back.sv
`timescale 1ns / 1ps
// Output stage of the deframer: a result register that drains the queue.
// Depends on tpd_pkg and tpd_if.
module tpd_back
  import tpd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  tpd_result_t   q_out,
  output logic          q_pop,
  tpd_result_if.source  out_ch
);

  logic        out_valid;
  tpd_result_t out_reg;

  assign q_pop = q_valid && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_reg <= q_out;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.data_byte    = out_reg.data_byte;
  assign out_ch.is_body      = out_reg.is_body;
  assign out_ch.last_of_part = out_reg.last_of_part;
  assign out_ch.empty_part   = out_reg.empty_part;
  assign out_ch.bad_header   = out_reg.bad_header;

  a_pop_fills_output: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> out_valid)
    else $error("result item taken from the queue was not presented");

endmodule

FILE: hdl/two_part_length_prefixed_deframer.sv
`timescale 1ns / 1ps
// Top level of the two-part length-prefixed deframer: parser, queue, output stage.
// Depends on tpd_pkg, tpd_if, tpd_front, tpd_queue and tpd_back.
//
//   Channel  Direction  Payload                                   Handshake
//   in_ch    sink       in_byte[7:0]                              valid/ready
//   out_ch   source     data_byte[7:0], is_body, last_of_part,    valid/ready
//                       empty_part, bad_header
//
// One byte is taken every cycle while the queue has room; the parser's state
// update is a single small add and compare, so that is what sets the rate.
// A result item is written into the queue when its byte is taken, and then into the output register.
// Reset (rst, synchronous) puts the parser at the name header and empties the
// queue and the output register; no clearing pass follows.
// A stalled output fills the two-entry queue, after which in_ch.ready drops.
//
// Each frame is a name part followed by a body part. A part begins with a
// header byte h (0 to 3), then h+1 length bytes, least significant first,
// then that many data bytes. Every data byte becomes one item tagged with its
// part; the final byte of the part carries last_of_part. A part of length zero
// gives a single marker item with empty_part and last_of_part set. A header
// byte above 3 gives one item with bad_header set, and parsing starts again
// at the name part. Header and length bytes on their own give no item.
// Length bits beyond LENGTH_WIDTH are dropped.
module two_part_length_prefixed_deframer
  import tpd_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  tpd_byte_if.sink     in_ch,
  tpd_result_if.source out_ch
);

  tpd_push_t   q_in;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  tpd_result_t q_out;

  // The parser only advances on a taken byte and pushes at most one item.
  tpd_front #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_in   (q_in)
  );

  // The queue lets the parser run on while the output side is stalled.
  tpd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_in    (q_in),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_out   (q_out)
  );

  // The output register refills in the same cycle that its item is taken, if the queue holds an item.
  tpd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_out   (q_out),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
